@@ sv/scc_pkg.sv @@
// shared widths and side-data types for the segment/circle collision pipeline
// no dependencies; used by scc_push, segment_circle_collision and the testbench
package scc_pkg;

  // fixed-point and field widths
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 16;
  localparam int RAD_W     = 15;
  localparam int DIFF_W    = 17;
  localparam int PROD_W    = 34;
  localparam int LEN_W     = 33;
  localparam int T_W       = 17;
  localparam int TPROD_W   = 35;
  localparam int E_W       = 36;
  localparam int MAG_W     = 31;
  localparam int SQ_W      = 62;
  localparam int E2_W      = 63;
  localparam int PART_W    = 17;
  localparam int PUSH_W    = 18;
  localparam int IN_W      = 112;
  localparam int OUT_W     = 40;

  // data carried alongside the projection divider
  typedef struct packed {
    logic                     ok;
    logic [RAD_W-1:0]         r;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] acx;
    logic signed [DIFF_W-1:0] acy;
    logic signed [DIFF_W-1:0] bcx;
    logic signed [DIFF_W-1:0] bcy;
  } seg_side_t;

  // data carried alongside the square root
  typedef struct packed {
    logic             act;
    logic             zero;
    logic             posx;
    logic             posy;
    logic             hit;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] rr;
    logic [RAD_W-1:0] r;
  } part_side_t;

  // data carried alongside the scaling divider
  typedef struct packed {
    logic             act;
    logic             zero;
    logic             posx;
    logic             hit;
    logic [RAD_W-1:0] r;
  } quo_side_t;

endpackage

@@ sv/scc_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// no package dependencies; used by scc_push and segment_circle_collision
module scc_div #(
  parameter int STEPS  = 17,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem0,
  input  logic [STEPS-1:0]  low,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [STEPS-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_q  [STEPS];
  logic [STEPS-1:0]  low_q  [STEPS];
  logic [STEPS-1:0]  quo_q  [STEPS];
  logic [DEN_W-1:0]  den_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic              vld_q  [STEPS];

  genvar j;
  for (j = 0; j < STEPS; j++) begin : g_step
    logic [DEN_W-1:0]  rem_p;
    logic [DEN_W-1:0]  den_p;
    logic [STEPS-1:0]  low_p;
    logic [STEPS-1:0]  quo_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [DEN_W:0]    trial;
    logic              ge;

    // stage input: module ports or the previous stage
    if (j == 0) begin : g_first
      assign rem_p  = rem0;
      assign den_p  = den;
      assign low_p  = low;
      assign quo_p  = '0;
      assign side_p = side_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign den_p  = den_q[j-1];
      assign low_p  = low_q[j-1];
      assign quo_p  = quo_q[j-1];
      assign side_p = side_q[j-1];
      assign vld_p  = vld_q[j-1];
    end

    // bring in the next numerator bit and try the subtraction
    assign trial = {rem_p, low_p[STEPS-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? DEN_W'(trial - {1'b0, den_p}) : trial[DEN_W-1:0];
        low_q[j]  <= low_p << 1;
        quo_q[j]  <= {quo_p[STEPS-2:0], ge};
        den_q[j]  <= den_p;
        side_q[j] <= side_p;
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign quo       = quo_q[STEPS-1];
  assign side_out  = side_q[STEPS-1];

endmodule

@@ sv/scc_push.sv @@
// one push part: range test, pipelined square root, scaling divide and sign
// depends on scc_pkg and scc_div
module scc_push (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic                               act,
  input  logic signed [scc_pkg::E_W-1:0]     ex,
  input  logic signed [scc_pkg::E_W-1:0]     ey,
  input  logic [scc_pkg::RAD_W-1:0]          r,
  output logic                               out_valid,
  output logic                               hit,
  output logic signed [scc_pkg::PART_W-1:0]  px,
  output logic signed [scc_pkg::PART_W-1:0]  py
);

  localparam int MW = scc_pkg::MAG_W;
  localparam int SQ_STEPS = scc_pkg::MAG_W;

  // stage 1: magnitudes, signs and coarse range gate
  logic [scc_pkg::E_W-1:0] magx, magy, rr_ext;
  logic [MW-1:0]           rr_c;
  logic                    v1;
  scc_pkg::part_side_t     s1;

  always_comb begin
    rr_c   = {r, {scc_pkg::FRAC_BITS{1'b0}}};
    rr_ext = scc_pkg::E_W'(rr_c);
    magx   = ex[scc_pkg::E_W-1] ? scc_pkg::E_W'(-ex) : scc_pkg::E_W'(ex);
    magy   = ey[scc_pkg::E_W-1] ? scc_pkg::E_W'(-ey) : scc_pkg::E_W'(ey);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.act  <= act;
      s1.zero <= (ex == '0) && (ey == '0);
      s1.posx <= !ex[scc_pkg::E_W-1] && (ex != '0);
      s1.posy <= !ey[scc_pkg::E_W-1] && (ey != '0);
      s1.hit  <= (magx <= rr_ext) && (magy <= rr_ext);
      s1.ax   <= magx[MW-1:0];
      s1.ay   <= magy[MW-1:0];
      s1.rr   <= rr_c;
      s1.r    <= r;
    end
  end

  // stage 2: squares
  logic [scc_pkg::SQ_W-1:0] sqx, sqy, rsq;
  logic                     v2;
  scc_pkg::part_side_t      s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= s1.ax * s1.ax;
      sqy <= s1.ay * s1.ay;
      rsq <= s1.rr * s1.rr;
      s2  <= s1;
    end
  end

  // stage 3: squared length and exact circle test
  logic [scc_pkg::E2_W-1:0] e2_c, e2;
  logic                     v3;
  scc_pkg::part_side_t      s3_c, s3;

  assign e2_c = scc_pkg::E2_W'(sqx) + scc_pkg::E2_W'(sqy);

  always_comb begin
    s3_c     = s2;
    s3_c.hit = s2.hit && (e2_c <= scc_pkg::E2_W'(rsq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2 <= e2_c;
      s3 <= s3_c;
    end
  end

  // square root, one result bit per stage, most significant first
  logic [scc_pkg::E2_W-1:0] sq_rem  [SQ_STEPS];
  logic [MW-1:0]            sq_res  [SQ_STEPS];
  scc_pkg::part_side_t      sq_side [SQ_STEPS];
  logic                     sq_vld  [SQ_STEPS];

  genvar j;
  for (j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int B = MW - 1 - j;
    logic [scc_pkg::E2_W-1:0] rem_p;
    logic [MW-1:0]            res_p;
    scc_pkg::part_side_t      side_p;
    logic                     vld_p;
    logic [63:0]              trial;
    logic                     ge;

    if (j == 0) begin : g_first
      assign rem_p  = e2;
      assign res_p  = '0;
      assign side_p = s3;
      assign vld_p  = v3;
    end else begin : g_next
      assign rem_p  = sq_rem[j-1];
      assign res_p  = sq_res[j-1];
      assign side_p = sq_side[j-1];
      assign vld_p  = sq_vld[j-1];
    end

    // (2*res + 2^b) * 2^b against the remainder
    assign trial = (64'(res_p) << (B + 1)) | (64'(1) << (2 * B));
    assign ge    = {1'b0, rem_p} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j] <= 1'b0;
      end else if (en) begin
        sq_vld[j] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j]  <= ge ? (rem_p - trial[scc_pkg::E2_W-1:0]) : rem_p;
        sq_res[j]  <= ge ? (res_p | (MW'(1) << B)) : res_p;
        sq_side[j] <= side_p;
      end
    end
  end

  // stage 4: depth scale (R - L) times each magnitude
  logic [scc_pkg::SQ_W-1:0] nx, ny;
  logic [MW-1:0]            len, kk;
  logic                     v4;
  scc_pkg::part_side_t      s4;
  scc_pkg::quo_side_t       qside_in, qside_out;

  assign kk = sq_side[SQ_STEPS-1].rr - sq_res[SQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_vld[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx  <= sq_side[SQ_STEPS-1].ax * kk;
      ny  <= sq_side[SQ_STEPS-1].ay * kk;
      len <= sq_res[SQ_STEPS-1];
      s4  <= sq_side[SQ_STEPS-1];
    end
  end

  // divide by the length; quotient is known to fit MAG_W bits
  logic          qx_v, qy_v;
  logic [MW-1:0] qx, qy;
  logic          posy_q;

  assign qside_in.act  = s4.act;
  assign qside_in.zero = s4.zero;
  assign qside_in.posx = s4.posx;
  assign qside_in.hit  = s4.hit;
  assign qside_in.r    = s4.r;

  scc_div #(
    .STEPS (MW),
    .DEN_W (MW),
    .SIDE_W($bits(scc_pkg::quo_side_t))
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .rem0     (nx[scc_pkg::SQ_W-1:MW]),
    .low      (nx[MW-1:0]),
    .den      (len),
    .side_in  (qside_in),
    .out_valid(qx_v),
    .quo      (qx),
    .side_out (qside_out)
  );

  scc_div #(
    .STEPS (MW),
    .DEN_W (MW),
    .SIDE_W(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .rem0     (ny[scc_pkg::SQ_W-1:MW]),
    .low      (ny[MW-1:0]),
    .den      (len),
    .side_in  (s4.posy),
    .out_valid(qy_v),
    .quo      (qy),
    .side_out (posy_q)
  );

  // stage 5: drop fraction, apply sign, handle the centre case
  logic signed [scc_pkg::PART_W-1:0] mx, my, rneg;

  always_comb begin
    mx   = scc_pkg::PART_W'(qx[MW-1:scc_pkg::FRAC_BITS]);
    my   = scc_pkg::PART_W'(qy[MW-1:scc_pkg::FRAC_BITS]);
    rneg = -scc_pkg::PART_W'(qside_out.r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= qx_v && qy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= qside_out.act && qside_out.hit;
      if (!(qside_out.act && qside_out.hit)) begin
        px <= '0;
        py <= '0;
      end else if (qside_out.zero) begin
        px <= rneg;
        py <= '0;
      end else begin
        px <= qside_out.posx ? -mx : mx;
        py <= posy_q ? -my : my;
      end
    end
  end

endmodule

@@ sv/segment_circle_collision.sv @@
// top level: segment/circle push vector, fully pipelined
// depends on scc_pkg, scc_div and scc_push
//
// One request on the s_ channel carries a segment A-B, a circle centre and
// a radius; one result on the m_ channel carries the three hit flags and
// the summed push vector (endpoint parts plus the projected-point part).
// A new request can be taken every cycle while s_tready is high. From acceptance
// to m_tvalid a request passes 4 set-up stages, the 17-stage projection divider,
// 2 stages forming the closest point, then 67 stages in each push unit
// (3 range stages, a 31-stage square root, a multiply stage, a 31-stage
// divider and a sign stage), all three push units running side by side,
// then the output register. Throughput is one result per cycle while
// m_tready stays high. Reset is synchronous and empties the pipeline.
// When the receiver stalls, the held result sits in the output register
// and one more result lands in a skid register; only then does s_tready
// drop and the whole pipeline freeze until the output is taken.
module segment_circle_collision (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // seg_ax, seg_ay, seg_bx, seg_by, center_x, center_y, radius, pad
  input  logic [scc_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // hit_segment, hit_start, hit_end, push_x, push_y, pad
  output logic [scc_pkg::OUT_W-1:0]  m_tdata
);

  localparam int CW = scc_pkg::COORD_W;
  localparam int DW = scc_pkg::DIFF_W;
  localparam int FB = scc_pkg::FRAC_BITS;
  localparam int EW = scc_pkg::E_W;

  logic skid_v;
  logic en;

  assign en       = !skid_v;
  assign s_tready = en;

  // stage 0: input register
  logic                 v0;
  logic signed [CW-1:0] ax0, ay0, bx0, by0, cx0, cy0;
  logic [scc_pkg::RAD_W-1:0] r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0 <= s_tdata[15:0];
      ay0 <= s_tdata[31:16];
      bx0 <= s_tdata[47:32];
      by0 <= s_tdata[63:48];
      cx0 <= s_tdata[79:64];
      cy0 <= s_tdata[95:80];
      r0  <= s_tdata[110:96];
    end
  end

  // stage 1: coordinate differences
  logic                 v1;
  logic signed [DW-1:0] dx1, dy1, ucx1, ucy1;
  scc_pkg::seg_side_t   d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1    <= DW'(bx0) - DW'(ax0);
      dy1    <= DW'(by0) - DW'(ay0);
      ucx1   <= DW'(cx0) - DW'(ax0);
      ucy1   <= DW'(cy0) - DW'(ay0);
      d1.ok  <= 1'b0;
      d1.r   <= r0;
      d1.dx  <= DW'(bx0) - DW'(ax0);
      d1.dy  <= DW'(by0) - DW'(ay0);
      d1.acx <= DW'(ax0) - DW'(cx0);
      d1.acy <= DW'(ay0) - DW'(cy0);
      d1.bcx <= DW'(bx0) - DW'(cx0);
      d1.bcy <= DW'(by0) - DW'(cy0);
    end
  end

  // stage 2: length and dot products
  logic                                 v2;
  logic signed [scc_pkg::PROD_W-1:0]    pxx, pyy, pdx, pdy;
  scc_pkg::seg_side_t                   d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx <= dx1 * dx1;
      pyy <= dy1 * dy1;
      pdx <= ucx1 * dx1;
      pdy <= ucy1 * dy1;
      d2  <= d1;
    end
  end

  // stage 3: len2, dot and the on-segment test
  logic [scc_pkg::LEN_W-1:0]          len2_c, len2;
  logic signed [scc_pkg::PROD_W:0]    dot_c;
  logic [scc_pkg::LEN_W-1:0]          dot3;
  logic                               v3;
  scc_pkg::seg_side_t                 d3_c, d3;

  always_comb begin
    len2_c  = scc_pkg::LEN_W'(pxx) + scc_pkg::LEN_W'(pyy);
    dot_c   = (scc_pkg::PROD_W+1)'(pdx) + (scc_pkg::PROD_W+1)'(pdy);
    d3_c    = d2;
    d3_c.ok = (len2_c != '0) && !dot_c[scc_pkg::PROD_W]
              && ((scc_pkg::PROD_W+1)'(len2_c) >= dot_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len2 <= len2_c;
      dot3 <= dot_c[scc_pkg::LEN_W-1:0];
      d3   <= d3_c;
    end
  end

  // projection parameter T = floor(dot * 2^F / len2), at most 2^F when the on-segment test passes
  logic                     tv;
  logic [scc_pkg::T_W-1:0]  tq;
  scc_pkg::seg_side_t       dt;

  scc_div #(
    .STEPS (scc_pkg::T_W),
    .DEN_W (scc_pkg::LEN_W),
    .SIDE_W($bits(scc_pkg::seg_side_t))
  ) u_proj_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .rem0     ({1'b0, dot3[scc_pkg::LEN_W-1:1]}),
    .low      ({dot3[0], {(scc_pkg::T_W-1){1'b0}}}),
    .den      (len2),
    .side_in  (d3),
    .out_valid(tv),
    .quo      (tq),
    .side_out (dt)
  );

  // stage 4: T times the segment direction
  logic                                v4;
  logic signed [scc_pkg::TPROD_W-1:0]  tx4, ty4;
  scc_pkg::seg_side_t                  d4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= tv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx4 <= $signed({1'b0, tq}) * $signed(dt.dx);
      ty4 <= $signed({1'b0, tq}) * $signed(dt.dy);
      d4  <= dt;
    end
  end

  // stage 5: offsets from the centre in fixed point
  logic                      v5, ok5;
  logic signed [EW-1:0]      ex_s, ey_s, ex_a, ey_a, ex_b, ey_b;
  logic [scc_pkg::RAD_W-1:0] r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_a <= EW'($signed(d4.acx)) <<< FB;
      ey_a <= EW'($signed(d4.acy)) <<< FB;
      ex_b <= EW'($signed(d4.bcx)) <<< FB;
      ey_b <= EW'($signed(d4.bcy)) <<< FB;
      ex_s <= (EW'($signed(d4.acx)) <<< FB) + EW'(tx4);
      ey_s <= (EW'($signed(d4.acy)) <<< FB) + EW'(ty4);
      ok5  <= d4.ok;
      r5   <= d4.r;
    end
  end

  // three push units in parallel
  logic                                pv_a, pv_b, pv_s;
  logic                                hit_a, hit_b, hit_s;
  logic signed [scc_pkg::PART_W-1:0]   px_a, py_a, px_b, py_b, px_s, py_s;

  scc_push u_push_start (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .act(1'b1),
    .ex(ex_a), .ey(ey_a), .r(r5),
    .out_valid(pv_a), .hit(hit_a), .px(px_a), .py(py_a)
  );

  scc_push u_push_end (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .act(1'b1),
    .ex(ex_b), .ey(ey_b), .r(r5),
    .out_valid(pv_b), .hit(hit_b), .px(px_b), .py(py_b)
  );

  scc_push u_push_seg (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5), .act(ok5),
    .ex(ex_s), .ey(ey_s), .r(r5),
    .out_valid(pv_s), .hit(hit_s), .px(px_s), .py(py_s)
  );

  // sum of parts, wrapping at the output width
  logic                                pv;
  logic signed [scc_pkg::PUSH_W-1:0]   sum_x, sum_y;
  logic [scc_pkg::OUT_W-1:0]           res_c;

  always_comb begin
    pv    = pv_a && pv_b && pv_s;
    sum_x = scc_pkg::PUSH_W'(px_a) + scc_pkg::PUSH_W'(px_b) + scc_pkg::PUSH_W'(px_s);
    sum_y = scc_pkg::PUSH_W'(py_a) + scc_pkg::PUSH_W'(py_b) + scc_pkg::PUSH_W'(py_s);
    res_c = {1'b0, sum_y, sum_x, hit_b, hit_a, hit_s};
  end

  // output register with one skid entry
  logic [scc_pkg::OUT_W-1:0] skid_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= pv;
      end else if (pv) begin
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= res_c;
      end else begin
        skid_d <= res_c;
      end
    end else if (m_tready) begin
      m_tdata <= skid_d;
    end
  end

endmodule

@@ tb/tb_segment_circle_collision.sv @@
// self-checking bench for segment_circle_collision: directed and random queries
// depends on scc_pkg and segment_circle_collision; exact push-vector predictor inside
module tb_segment_circle_collision;

  typedef struct {
    logic signed [15:0] ax, ay, bx, by, cx, cy;
    logic [14:0]        r;
  } query_t;

  typedef struct {
    logic        hit_segment, hit_start, hit_end;
    logic [17:0] push_x, push_y;
  } push_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [scc_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [scc_pkg::OUT_W-1:0] m_tdata;

  query_t pending_q[$];
  push_t  expected_q[$];
  query_t on_bus;
  int     send_idle = 0;
  int     recv_stall = 0;
  int     hold_req = 0;
  int     hold_cnt = 0;
  int     errors = 0;
  int     quiet = 0;

  segment_circle_collision dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // one push part for offset (ex, ey) with 16 fraction bits
  function automatic void part_push(input longint ex, input longint ey, input longint r,
                                    output bit hit, output longint px, output longint py);
    logic [127:0] mx_a, my_a, e2, rf, root, c, k, mx, my;
    mx_a = ex < 0 ? 128'(-ex) : 128'(ex);
    my_a = ey < 0 ? 128'(-ey) : 128'(ey);
    rf   = 128'(r) << 16;
    e2   = mx_a * mx_a + my_a * my_a;
    hit = 0; px = 0; py = 0;
    if (e2 > rf * rf) return;
    hit = 1;
    if (e2 == 0) begin
      px = -r;
      return;
    end
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= e2) root = c;
    end
    k  = rf - root;
    mx = (mx_a * k / root) >> 16;
    my = (my_a * k / root) >> 16;
    px = ex > 0 ? -longint'(mx) : longint'(mx);
    py = ey > 0 ? -longint'(my) : longint'(my);
  endfunction

  // expected flags and summed push for one query
  function automatic push_t collision_push(input query_t q);
    push_t  res;
    longint ax, ay, bx, by, cx, cy, r, dx, dy, dot, len2, t, px, py, sx, sy;
    bit     h;
    ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; cx = q.cx; cy = q.cy; r = q.r;
    sx = 0; sy = 0;
    part_push((ax - cx) * 65536, (ay - cy) * 65536, r, h, px, py);
    res.hit_start = h; sx += px; sy += py;
    part_push((bx - cx) * 65536, (by - cy) * 65536, r, h, px, py);
    res.hit_end = h; sx += px; sy += py;
    res.hit_segment = 0;
    dx = bx - ax; dy = by - ay;
    len2 = dx * dx + dy * dy;
    dot  = (cx - ax) * dx + (cy - ay) * dy;
    if (len2 != 0 && dot >= 0 && dot <= len2) begin
      t = (dot * 65536) / len2;
      part_push((ax - cx) * 65536 + t * dx, (ay - cy) * 65536 + t * dy, r, h, px, py);
      res.hit_segment = h; sx += px; sy += py;
    end
    res.push_x = sx[17:0];
    res.push_y = sy[17:0];
    return res;
  endfunction

  function automatic query_t mk(input int ax, ay, bx, by, cx, cy, r);
    query_t q;
    q.ax = ax[15:0]; q.ay = ay[15:0]; q.bx = bx[15:0]; q.by = by[15:0];
    q.cx = cx[15:0]; q.cy = cy[15:0]; q.r = r[14:0];
    return q;
  endfunction

  // random query: mostly points scattered around the circle, some full-range noise
  function automatic query_t rand_query();
    query_t q;
    int r, span;
    if ($urandom_range(99) < 15) begin
      q.ax = 16'($urandom); q.ay = 16'($urandom); q.bx = 16'($urandom);
      q.by = 16'($urandom); q.cx = 16'($urandom); q.cy = 16'($urandom);
      q.r = 15'($urandom);
      return q;
    end
    r = $urandom_range(99) < 85 ? $urandom_range(0, 300) : $urandom_range(0, 32767);
    span = 2 * r + 4;
    q.cx = 16'($urandom); q.cy = 16'($urandom); q.r = r[14:0];
    q.ax = q.cx + 16'($urandom_range(0, 2 * span) - span);
    q.ay = q.cy + 16'($urandom_range(0, 2 * span) - span);
    case ($urandom_range(3))
      0: begin q.bx = q.ax; q.by = q.ay; end
      1: begin q.bx = q.cx; q.by = q.cy + 16'($urandom_range(0, 2 * span) - span); end
      default: begin
        q.bx = q.cx + 16'($urandom_range(0, 2 * span) - span);
        q.by = q.cy + 16'($urandom_range(0, 2 * span) - span);
      end
    endcase
    return q;
  endfunction

  // request driver; records the expectation when a request is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(collision_push(on_bus));
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          on_bus = pending_q.pop_front();
          // seg_ax, seg_ay, seg_bx, seg_by, center_x, center_y, radius, pad
          s_tdata <= {1'b0, on_bus.r, on_bus.cy, on_bus.cx, on_bus.by, on_bus.bx,
                      on_bus.ay, on_bus.ax};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req > 0 && hold_cnt == 0) begin
      hold_cnt <= hold_req;
      hold_req = 0;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall;
    end
  end

  // result checker
  always @(posedge clk) begin
    push_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[0] !== e.hit_segment) begin
          $error("hit_segment exp %0d got %0d", e.hit_segment, m_tdata[0]); errors++;
        end
        if (m_tdata[1] !== e.hit_start) begin
          $error("hit_start exp %0d got %0d", e.hit_start, m_tdata[1]); errors++;
        end
        if (m_tdata[2] !== e.hit_end) begin
          $error("hit_end exp %0d got %0d", e.hit_end, m_tdata[2]); errors++;
        end
        if (m_tdata[20:3] !== e.push_x) begin
          $error("push_x exp %0d got %0d", $signed(e.push_x), $signed(m_tdata[20:3]));
          errors++;
        end
        if (m_tdata[38:21] !== e.push_y) begin
          $error("push_y exp %0d got %0d", $signed(e.push_y), $signed(m_tdata[38:21]));
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("** segment_circle_collision: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    pending_q.push_back(mk(0, 0, 10, 0, 5, 0, 0));
    pending_q.push_back(mk(0, 0, 10, 0, 5, 0, 3));
    pending_q.push_back(mk(5, 5, 5, 5, 5, 5, 7));
    pending_q.push_back(mk(3, 4, 3, 4, 0, 0, 5));
    pending_q.push_back(mk(0, 0, 20, 0, 30, 1, 5));
    pending_q.push_back(mk(0, 0, 20, 0, -9, 1, 5));
    pending_q.push_back(mk(0, 0, 20, 0, 10, 50, 5));
    pending_q.push_back(mk(-10, 3, 10, 3, 0, 0, 5));
    pending_q.push_back(mk(0, 2, 0, -2, 0, 0, 3));
    pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 32767));
    pending_q.push_back(mk(32767, 32767, -32768, -32768, 0, 0, 32767));
    pending_q.push_back(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    pending_q.push_back(mk(-32768, 32767, 32767, -32768, -32768, -32768, 0));
    pending_q.push_back(mk(100, 0, 100, 0, 0, 0, 32767));
    pending_q.push_back(mk(-20000, 1, 20000, 1, 0, 0, 32767));
    pending_q.push_back(mk(32767, -32768, 32767, 32767, 32767, 0, 32767));
    pending_q.push_back(mk(1, 1, 2, 2, 0, 0, 1));
    pending_q.push_back(mk(0, 0, 7, 7, 0, 0, 0));
    drain();

    // random phases with varying backpressure
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        3: begin send_idle = 26; recv_stall = 26; end
        default: begin send_idle = 0; recv_stall = 0; hold_req = 400; end
      endcase
      for (int i = 0; i < 350; i++) pending_q.push_back(rand_query());
      drain();
    end

    repeat (120) @(posedge clk);
    if (errors == 0 && !m_tvalid) $display("** segment_circle_collision: PASSED **");
    else $display("** segment_circle_collision: FAILED **");
    $finish;
  end

endmodule
